// ===== hdl/ccoal_pkg.sv =====
// Shared constants and types for the copy request coalescer.
package ccoal_pkg;

  // Width of the offset and length ports.
  localparam int PORT_BITS = 64;
  // Default width of the offset arithmetic.
  localparam int OFFSET_BITS_DEF = 64;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] dir_t;

  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_ASSIGN = 2'd1;
  localparam op_t OP_MERGE  = 2'd2;
  localparam op_t OP_TRIM   = 2'd3;

  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_DIR = 2'd1;
  localparam status_t ST_ADJ = 2'd2;
  localparam status_t ST_OVF = 2'd3;

  // Storage to storage; also the direction of an empty request.
  localparam dir_t DIR_S2S = 2'd3;

endpackage

// ===== hdl/copy_request_coalescer.sv =====
// Copy request coalescer: holds one pending copy request and applies one operation per item.
//
// Input channel (in_*): each item carries an operation (clear, assign, coalesce,
// remove front) and its operands. Result channel (out_*): each item gives a status
// and the request held after that operation. Both channels use valid/stall; an item
// moves on an edge where valid is high and stall is low.
// An accepted item passes through the input register and then the result register to out_*.
// Throughput: one item per cycle while out_stall is low. The held request lives in a
// single register set that is read and written in the same cycle as the output
// register loads, so back-to-back items see each other's effect.
// When out_stall holds the result register, the input register keeps its item and
// in_stall rises; the held request does not change until the result moves on.
// Reset (rst_n low, synchronous) empties both pipeline registers and sets the held
// request to offsets 0, length 0, direction storage to storage.
// Offsets and lengths are OFFSET_BITS wide; higher input bits are ignored and
// higher output bits read as zero.
module copy_request_coalescer #(
  parameter int OFFSET_BITS = ccoal_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ccoal_pkg::op_t                    in_op,
  input  logic [ccoal_pkg::PORT_BITS-1:0]   in_src_offset,
  input  logic [ccoal_pkg::PORT_BITS-1:0]   in_dst_offset,
  input  logic [ccoal_pkg::PORT_BITS-1:0]   in_span_length,
  input  ccoal_pkg::dir_t                   in_direction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ccoal_pkg::status_t                out_status,
  output logic [ccoal_pkg::PORT_BITS-1:0]   out_held_src,
  output logic [ccoal_pkg::PORT_BITS-1:0]   out_held_dst,
  output logic [ccoal_pkg::PORT_BITS-1:0]   out_held_length,
  output ccoal_pkg::dir_t                   out_held_direction
);

  localparam int W  = OFFSET_BITS;
  localparam int PB = ccoal_pkg::PORT_BITS;

  // Input register.
  logic               s1_valid_r;
  ccoal_pkg::op_t     s1_op_r;
  logic [W-1:0]       s1_src_r;
  logic [W-1:0]       s1_dst_r;
  logic [W-1:0]       s1_len_r;
  ccoal_pkg::dir_t    s1_dir_r;

  // Held request.
  logic [W-1:0]       pend_src_r;
  logic [W-1:0]       pend_dst_r;
  logic [W-1:0]       pend_len_r;
  ccoal_pkg::dir_t    pend_dir_r;

  // Result register.
  logic               out_valid_r;
  ccoal_pkg::status_t out_status_r;
  logic [W-1:0]       out_src_r;
  logic [W-1:0]       out_dst_r;
  logic [W-1:0]       out_len_r;
  ccoal_pkg::dir_t    out_dir_r;

  // Next values of the held request and the status.
  logic [W-1:0]       pend_src_nxt;
  logic [W-1:0]       pend_dst_nxt;
  logic [W-1:0]       pend_len_nxt;
  ccoal_pkg::dir_t    pend_dir_nxt;
  ccoal_pkg::status_t status_nxt;

  logic               out_free;
  logic               out_load;
  logic               in_take;

  logic [W-1:0]       big_sd;
  logic [W-1:0]       big_sdl;
  logic [W:0]         put_sum;
  logic [W:0]         merge_sum;
  logic [W-1:0]       src_end;
  logic [W-1:0]       dst_end;
  logic [W-1:0]       pend_src_end;
  logic [W-1:0]       pend_dst_end;
  logic [W-1:0]       pend_src_adv;
  logic [W-1:0]       pend_dst_adv;
  logic [W-1:0]       merged_len;
  logic               put_ovf;
  logic               merge_ovf;
  logic               at_front;
  logic               at_back;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= in_op;
      s1_src_r <= in_src_offset[W-1:0];
      s1_dst_r <= in_dst_offset[W-1:0];
      s1_len_r <= in_span_length[W-1:0];
      s1_dir_r <= in_direction;
    end
  end

  // Operand arithmetic, all in parallel.
  always_comb begin
    big_sd       = (s1_src_r > s1_dst_r) ? s1_src_r : s1_dst_r;
    big_sdl      = (big_sd > pend_len_r) ? big_sd : pend_len_r;
    put_sum      = {1'b0, big_sd} + {1'b0, s1_len_r};
    merge_sum    = {1'b0, big_sdl} + {1'b0, s1_len_r};
    put_ovf      = put_sum[W];
    merge_ovf    = merge_sum[W];
    src_end      = s1_src_r + s1_len_r;
    dst_end      = s1_dst_r + s1_len_r;
    pend_src_end = pend_src_r + pend_len_r;
    pend_dst_end = pend_dst_r + pend_len_r;
    pend_src_adv = pend_src_r + s1_len_r;
    pend_dst_adv = pend_dst_r + s1_len_r;
    merged_len   = pend_len_r + s1_len_r;
    at_front     = (src_end == pend_src_r) && (dst_end == pend_dst_r);
    at_back      = (pend_src_end == s1_src_r) && (pend_dst_end == s1_dst_r);
  end

  always_comb begin
    pend_src_nxt = pend_src_r;
    pend_dst_nxt = pend_dst_r;
    pend_len_nxt = pend_len_r;
    pend_dir_nxt = pend_dir_r;
    status_nxt   = ccoal_pkg::ST_OK;
    case (s1_op_r)
      ccoal_pkg::OP_CLEAR: begin
        pend_src_nxt = '0;
        pend_dst_nxt = '0;
        pend_len_nxt = '0;
        pend_dir_nxt = ccoal_pkg::DIR_S2S;
      end
      ccoal_pkg::OP_ASSIGN: begin
        if (put_ovf) begin
          status_nxt = ccoal_pkg::ST_OVF;
        end else begin
          pend_src_nxt = s1_src_r;
          pend_dst_nxt = s1_dst_r;
          pend_len_nxt = s1_len_r;
          pend_dir_nxt = s1_dir_r;
        end
      end
      ccoal_pkg::OP_MERGE: begin
        // An empty request takes the new one as a plain assign.
        if (pend_len_r == '0) begin
          if (put_ovf) begin
            status_nxt = ccoal_pkg::ST_OVF;
          end else begin
            pend_src_nxt = s1_src_r;
            pend_dst_nxt = s1_dst_r;
            pend_len_nxt = s1_len_r;
            pend_dir_nxt = s1_dir_r;
          end
        end else if (pend_dir_r != s1_dir_r) begin
          status_nxt = ccoal_pkg::ST_DIR;
        end else if (merge_ovf) begin
          status_nxt = ccoal_pkg::ST_OVF;
        end else if (at_front) begin
          pend_src_nxt = s1_src_r;
          pend_dst_nxt = s1_dst_r;
          pend_len_nxt = merged_len;
          pend_dir_nxt = s1_dir_r;
        end else if (at_back) begin
          pend_len_nxt = merged_len;
          pend_dir_nxt = s1_dir_r;
        end else begin
          status_nxt = ccoal_pkg::ST_ADJ;
        end
      end
      default: begin
        if (pend_len_r == s1_len_r) begin
          pend_src_nxt = '0;
          pend_dst_nxt = '0;
          pend_len_nxt = '0;
          pend_dir_nxt = ccoal_pkg::DIR_S2S;
        end else if (pend_len_r > s1_len_r) begin
          pend_src_nxt = pend_src_adv;
          pend_dst_nxt = pend_dst_adv;
          pend_len_nxt = pend_len_r - s1_len_r;
        end else begin
          status_nxt = ccoal_pkg::ST_OVF;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_src_r <= '0;
      pend_dst_r <= '0;
      pend_len_r <= '0;
      pend_dir_r <= ccoal_pkg::DIR_S2S;
    end else if (out_load) begin
      pend_src_r <= pend_src_nxt;
      pend_dst_r <= pend_dst_nxt;
      pend_len_r <= pend_len_nxt;
      pend_dir_r <= pend_dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_nxt;
      out_src_r    <= pend_src_nxt;
      out_dst_r    <= pend_dst_nxt;
      out_len_r    <= pend_len_nxt;
      out_dir_r    <= pend_dir_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_held_src       = PB'(out_src_r);
  assign out_held_dst       = PB'(out_dst_r);
  assign out_held_length    = PB'(out_len_r);
  assign out_held_direction = out_dir_r;

endmodule

// ===== hdl/ccoal_checker.sv =====
// Port-level checks for the copy request coalescer, bound to the top level.
module ccoal_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input ccoal_pkg::op_t                  in_op,
  input logic [ccoal_pkg::PORT_BITS-1:0] in_src_offset,
  input logic [ccoal_pkg::PORT_BITS-1:0] in_dst_offset,
  input logic [ccoal_pkg::PORT_BITS-1:0] in_span_length,
  input ccoal_pkg::dir_t                 in_direction,
  input logic                            out_valid,
  input logic                            out_stall,
  input ccoal_pkg::status_t              out_status,
  input logic [ccoal_pkg::PORT_BITS-1:0] out_held_src,
  input logic [ccoal_pkg::PORT_BITS-1:0] out_held_dst,
  input logic [ccoal_pkg::PORT_BITS-1:0] out_held_length,
  input ccoal_pkg::dir_t                 out_held_direction
);

  // Items taken in but not yet delivered; the block holds at most two.
  logic [2:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_held_src) && $stable(out_held_dst) &&
      $stable(out_held_length) && $stable(out_held_direction))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0 && inflight_r <= 3'd2)
    else $error("result without a pending item, or too many items in flight");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 3'd2 && out_stall |-> in_stall)
    else $error("item accepted with both registers full and the output stalled");

  // A direction mismatch or a non-adjacent merge leaves a non-empty request held.
  a_err_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ccoal_pkg::ST_DIR || out_status == ccoal_pkg::ST_ADJ)
      |-> out_held_length != '0)
    else $error("merge error reported against an empty request");

endmodule

bind copy_request_coalescer ccoal_checker u_ccoal_checker (.*);

// ===== tb/copy_request_checker.sv =====
// Checker for the copy request coalescer: predicts each result and compares it.
module copy_request_checker
  import ccoal_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  op_t                  in_op,
  input  logic [PORT_BITS-1:0] in_src_offset,
  input  logic [PORT_BITS-1:0] in_dst_offset,
  input  logic [PORT_BITS-1:0] in_span_length,
  input  dir_t                 in_direction,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  status_t              out_status,
  input  logic [PORT_BITS-1:0] out_held_src,
  input  logic [PORT_BITS-1:0] out_held_dst,
  input  logic [PORT_BITS-1:0] out_held_length,
  input  dir_t                 out_held_direction,
  output int                   fail_count,
  output int                   results_owed
);

  typedef struct packed {
    status_t              status;
    logic [PORT_BITS-1:0] src;
    logic [PORT_BITS-1:0] dst;
    logic [PORT_BITS-1:0] len;
    dir_t                 dir;
  } held_view_t;

  localparam logic [PORT_BITS-1:0] LIM = {PORT_BITS{1'b1}} >> (PORT_BITS - OFFSET_BITS);

  logic [PORT_BITS-1:0] req_src;
  logic [PORT_BITS-1:0] req_dst;
  logic [PORT_BITS-1:0] req_len;
  dir_t                 req_dir;
  held_view_t           owed_views[$];

  assign results_owed = owed_views.size();

  initial fail_count = 0;

  function automatic void empty_request();
    req_src = '0;
    req_dst = '0;
    req_len = '0;
    req_dir = DIR_S2S;
  endfunction

  function automatic logic [PORT_BITS-1:0] larger(logic [PORT_BITS-1:0] a,
                                                  logic [PORT_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic bit fits(logic [PORT_BITS-1:0] a, logic [PORT_BITS-1:0] b);
    return b <= (LIM - a);
  endfunction

  function automatic status_t place_request(logic [PORT_BITS-1:0] s, logic [PORT_BITS-1:0] d,
                                            logic [PORT_BITS-1:0] n, dir_t dir);
    if (!fits(larger(s, d), n)) return ST_OVF;
    req_src = s;
    req_dst = d;
    req_len = n;
    req_dir = dir;
    return ST_OK;
  endfunction

  // Applies one item to the held request and returns the result it should produce.
  function automatic held_view_t step_request(op_t op, logic [PORT_BITS-1:0] s_in,
                                              logic [PORT_BITS-1:0] d_in,
                                              logic [PORT_BITS-1:0] n_in, dir_t dir);
    logic [PORT_BITS-1:0] s, d, n;
    held_view_t r;
    s = s_in & LIM;
    d = d_in & LIM;
    n = n_in & LIM;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: empty_request();
      OP_ASSIGN: r.status = place_request(s, d, n, dir);
      OP_MERGE: begin
        if (req_len == 0) begin
          r.status = place_request(s, d, n, dir);
        end else if (req_dir != dir) begin
          r.status = ST_DIR;
        end else if (!fits(larger(larger(s, d), req_len), n)) begin
          r.status = ST_OVF;
        end else if (((s + n) & LIM) == req_src && ((d + n) & LIM) == req_dst) begin
          // The new request ends where the held one starts.
          req_src = s;
          req_dst = d;
          req_len = (req_len + n) & LIM;
          req_dir = dir;
        end else if (((req_src + req_len) & LIM) == s && ((req_dst + req_len) & LIM) == d) begin
          req_len = (req_len + n) & LIM;
          req_dir = dir;
        end else begin
          r.status = ST_ADJ;
        end
      end
      default: begin
        if (req_len == n) begin
          empty_request();
        end else if (req_len > n) begin
          req_src = (req_src + n) & LIM;
          req_dst = (req_dst + n) & LIM;
          req_len = req_len - n;
        end else begin
          r.status = ST_OVF;
        end
      end
    endcase
    r.src = req_src;
    r.dst = req_dst;
    r.len = req_len;
    r.dir = req_dir;
    return r;
  endfunction

  task automatic check_field(string name, logic [PORT_BITS-1:0] got, logic [PORT_BITS-1:0] want);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    held_view_t want;
    if (!rst_n) begin
      owed_views.delete();
      empty_request();
    end else begin
      if (in_valid && !in_stall) begin
        owed_views.push_back(step_request(in_op, in_src_offset, in_dst_offset,
                                          in_span_length, in_direction));
      end
      if (out_valid && !out_stall) begin
        if (owed_views.size() == 0) begin
          $display("%0t: result with none expected, got status %0d length %h",
                   $time, out_status, out_held_length);
          fail_count++;
        end else begin
          want = owed_views.pop_front();
          check_field("status", PORT_BITS'(out_status), PORT_BITS'(want.status));
          check_field("held_src", out_held_src, want.src);
          check_field("held_dst", out_held_dst, want.dst);
          check_field("held_length", out_held_length, want.len);
          check_field("held_direction", PORT_BITS'(out_held_direction), PORT_BITS'(want.dir));
        end
      end
    end
  end

endmodule

// ===== tb/copy_request_coalescer_tb.sv =====
// Testbench top for the copy request coalescer: clock, reset, stimulus and verdict.
module copy_request_coalescer_tb;
  import ccoal_pkg::*;

  localparam logic [PORT_BITS-1:0] ALL_ONES = {PORT_BITS{1'b1}};
  localparam int RANDOM_ITEMS = 1950;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  op_t                  in_op = OP_CLEAR;
  logic [PORT_BITS-1:0] in_src_offset = '0;
  logic [PORT_BITS-1:0] in_dst_offset = '0;
  logic [PORT_BITS-1:0] in_span_length = '0;
  dir_t                 in_direction = DIR_S2S;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  status_t              out_status;
  logic [PORT_BITS-1:0] out_held_src;
  logic [PORT_BITS-1:0] out_held_dst;
  logic [PORT_BITS-1:0] out_held_length;
  dir_t                 out_held_direction;
  int                   fail_count;
  int                   results_owed;
  int unsigned          stall_run = 0;
  int                   items_sent = 0;
  bit                   steady = 1'b0;

  copy_request_coalescer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_src_offset     (in_src_offset),
    .in_dst_offset     (in_dst_offset),
    .in_span_length    (in_span_length),
    .in_direction      (in_direction),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_held_src      (out_held_src),
    .out_held_dst      (out_held_dst),
    .out_held_length   (out_held_length),
    .out_held_direction(out_held_direction)
  );

  copy_request_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_src_offset     (in_src_offset),
    .in_dst_offset     (in_dst_offset),
    .in_span_length    (in_span_length),
    .in_direction      (in_direction),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_held_src      (out_held_src),
    .out_held_dst      (out_held_dst),
    .out_held_length   (out_held_length),
    .out_held_direction(out_held_direction),
    .fail_count        (fail_count),
    .results_owed      (results_owed)
  );

  always #5 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PORT_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PORT_BITS-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return PORT_BITS'($urandom_range(1, 4096));
    if (r == 7) return '0;
    if (r == 8) return PORT_BITS'($urandom_range(1, 1 << 30));
    return rand64();
  endfunction

  // The result side stalls in bursts, with occasional long quiet stretches.
  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run <= gap_len();
    end else begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
    end
  end

  task automatic send_item(op_t op, logic [PORT_BITS-1:0] s, logic [PORT_BITS-1:0] d,
                           logic [PORT_BITS-1:0] n, dir_t dir);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_src_offset <= s;
    in_dst_offset <= d;
    in_span_length <= n;
    in_direction <= dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // One more edge first, so the item accepted last is already counted as owed.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    @(posedge clk);
  endtask

  // A request built up piece by piece, with a few broken items mixed in.
  task automatic run_sequence();
    logic [PORT_BITS-1:0] ps, pd, pl, n;
    dir_t pdir;
    int unsigned pick, steps;
    case ($urandom_range(0, 9))
      0: begin
        ps = rand64();
        pd = rand64();
      end
      1: begin
        ps = ALL_ONES - $urandom_range(0, 65535);
        pd = ALL_ONES - $urandom_range(0, 65535);
      end
      default: begin
        ps = PORT_BITS'($urandom_range(0, 1 << 20));
        pd = PORT_BITS'($urandom_range(0, 1 << 20));
      end
    endcase
    pl = pick_len();
    pdir = dir_t'($urandom_range(0, 3));
    send_item(($urandom_range(0, 3) == 0) ? OP_MERGE : OP_ASSIGN, ps, pd, pl, pdir);
    steps = $urandom_range(2, 10);
    for (int k = 0; k < steps; k++) begin
      n = pick_len();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_item(OP_MERGE, ps + pl, pd + pl, n, pdir);
        pl = pl + n;
      end else if (pick < 60) begin
        send_item(OP_MERGE, ps - n, pd - n, n, pdir);
        ps = ps - n;
        pd = pd - n;
        pl = pl + n;
      end else if (pick < 78) begin
        n = (pl < 2) ? '0 : 1 + (rand64() % (pl - 1));
        send_item(OP_TRIM, rand64(), rand64(), n, dir_t'($urandom_range(0, 3)));
        ps = ps + n;
        pd = pd + n;
        pl = pl - n;
      end else if (pick < 84) begin
        send_item(OP_TRIM, rand64(), rand64(), pl, pdir);
        ps = ps + pl;
        pd = pd + pl;
        pl = '0;
      end else if (pick < 89) begin
        send_item(OP_MERGE, ps + pl, pd + pl, n, pdir ^ dir_t'($urandom_range(1, 3)));
      end else if (pick < 94) begin
        // Adjacent on one side only.
        if ($urandom_range(0, 1) == 0)
          send_item(OP_MERGE, ps + pl + 1, pd + pl, n, pdir);
        else
          send_item(OP_MERGE, ps - n, pd - n - 1, n, pdir);
      end else if (pick < 97) begin
        send_item(OP_TRIM, ps, pd, pl + 1 + $urandom_range(0, 100), pdir);
      end else begin
        send_item(OP_CLEAR, rand64(), rand64(), rand64(), dir_t'($urandom_range(0, 3)));
        pl = '0;
      end
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every operation, each status and the boundary cases.
    send_item(OP_CLEAR, '0, '0, '0, 2'd0);
    send_item(OP_TRIM, '0, '0, '0, 2'd0);
    send_item(OP_TRIM, '0, '0, 64'd1, 2'd0);
    send_item(OP_MERGE, 64'd100, 64'd200, 64'd10, 2'd0);
    send_item(OP_MERGE, 64'd110, 64'd210, 64'd5, 2'd0);
    send_item(OP_MERGE, 64'd90, 64'd190, 64'd10, 2'd0);
    send_item(OP_MERGE, 64'd115, 64'd215, 64'd3, 2'd1);
    send_item(OP_MERGE, 64'd500, 64'd600, 64'd3, 2'd0);
    send_item(OP_MERGE, ALL_ONES - 5, '0, 64'd10, 2'd0);
    send_item(OP_TRIM, '0, '0, 64'd5, 2'd0);
    send_item(OP_TRIM, '0, '0, 64'd1000, 2'd0);
    send_item(OP_TRIM, '0, '0, 64'd20, 2'd0);
    send_item(OP_ASSIGN, ALL_ONES, '0, 64'd1, 2'd2);
    send_item(OP_ASSIGN, ALL_ONES - 7, 64'd3, 64'd8, 2'd2);
    send_item(OP_ASSIGN, 64'd5, 64'd6, '0, 2'd1);
    send_item(OP_MERGE, 64'd1000, 64'd2000, 64'd50, DIR_S2S);
    send_item(OP_MERGE, 64'd1050, 64'd2050, 64'd16, DIR_S2S);
    send_item(OP_ASSIGN, ALL_ONES, ALL_ONES, '0, DIR_S2S);
    send_item(OP_ASSIGN, '0, '0, ALL_ONES, 2'd0);
    send_item(OP_TRIM, ALL_ONES, ALL_ONES, ALL_ONES - 1, DIR_S2S);
    send_item(OP_MERGE, ALL_ONES, ALL_ONES, '0, 2'd0);
    send_item(OP_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, DIR_S2S);
    send_item(OP_ASSIGN, 64'd1000, 64'd3000, 64'd100, 2'd1);
    send_item(OP_MERGE, 64'd900, 64'd2950, 64'd100, 2'd1);
    send_item(OP_MERGE, 64'd1100, 64'd3100, 64'd7, 2'd1);
    wait_for_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 7)
        run_sequence();
      else
        send_item(op_t'($urandom_range(0, 3)), rand64(), rand64(), rand64(),
                  dir_t'($urandom_range(0, 3)));
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ccoal_pkg.sv
hdl/copy_request_coalescer.sv
hdl/ccoal_checker.sv
tb/copy_request_checker.sv
tb/copy_request_coalescer_tb.sv
